// ----- sv/pdd_pkg.sv -----
package pdd_pkg;

  localparam int PosWidth   = 24;
  localparam int InchWidth  = 13;
  localparam int GainWidth  = 16;
  localparam int TickWidth  = 21;
  localparam int ErrWidth   = 25;
  localparam int DerivWidth = 26;
  localparam int SumWidth   = 32;
  localparam int DriveWidth = 8;

  localparam int PowerLimit       = 100;
  localparam int StopBand         = 2;
  localparam int IntegralZone     = 10;
  // 180 * 3.14 / 4.125 ticks per inch, unsigned Q.8
  localparam int TicksPerInchQ8   = 35077;

  typedef enum logic [1:0] {
    REG_TARGET_INCHES = 2'd0,
    REG_GAIN_P        = 2'd1,
    REG_GAIN_I        = 2'd2,
    REG_GAIN_D        = 2'd3
  } pdd_reg_t;

  typedef struct packed {
    logic signed [ErrWidth-1:0]   err;
    logic signed [DerivWidth-1:0] deriv;
    logic signed [SumWidth-1:0]   isum;
    logic                         on_target;
  } pdd_step_t;

endpackage

// ----- sv/pdd_front.sv -----
module pdd_front
  import pdd_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [PosWidth-1:0]         s_tdata,
  input  logic                        s_tuser,
  input  logic signed [TickWidth-1:0] target_ticks,
  output logic                        step_valid,
  input  logic                        step_ready,
  output pdd_step_t                   step
);

  logic                       in_valid;
  logic [PosWidth-1:0]        in_pos;
  logic                       in_start;
  logic                       in_ready;

  logic signed [SumWidth-1:0] error_sum;
  logic signed [ErrWidth-1:0] previous_error;

  logic signed [ErrWidth-1:0]   err;
  logic [ErrWidth-1:0]          err_mag;
  logic                         on_tgt;
  logic                         in_zone;
  logic signed [SumWidth-1:0]   sum_base;
  logic signed [ErrWidth-1:0]   prev_base;
  logic signed [SumWidth:0]     sum_add;
  logic signed [SumWidth-1:0]   error_sum_next;
  logic signed [DerivWidth-1:0] deriv;
  logic                         advance;

  assign in_ready = !in_valid || !step_valid || step_ready;
  assign s_tready = in_ready;
  assign advance  = in_valid && in_ready;

  always_comb begin
    err = {{(ErrWidth-TickWidth){target_ticks[TickWidth-1]}}, target_ticks}
        - {{(ErrWidth-PosWidth){in_pos[PosWidth-1]}}, in_pos};
    err_mag = err[ErrWidth-1] ? ErrWidth'(-err) : ErrWidth'(err);
    on_tgt  = err_mag <= ErrWidth'(StopBand);
    in_zone = err_mag < ErrWidth'(IntegralZone);
    // a move start clears the integral and zeroes the first derivative
    sum_base  = in_start ? '0 : error_sum;
    prev_base = in_start ? err : previous_error;
    sum_add = {sum_base[SumWidth-1], sum_base}
            + {{(SumWidth+1-ErrWidth){err[ErrWidth-1]}}, err};
    if (on_tgt || !in_zone) begin
      error_sum_next = sum_base;
    end else if (sum_add[SumWidth] != sum_add[SumWidth-1]) begin
      error_sum_next = sum_add[SumWidth] ? {1'b1, {(SumWidth-1){1'b0}}}
                                         : {1'b0, {(SumWidth-1){1'b1}}};
    end else begin
      error_sum_next = sum_add[SumWidth-1:0];
    end
    deriv = {err[ErrWidth-1], err} - {prev_base[ErrWidth-1], prev_base};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      step_valid     <= 1'b0;
      error_sum      <= '0;
      previous_error <= '0;
    end else begin
      if (in_ready) begin
        in_valid <= s_tvalid;
      end
      if (!step_valid || step_ready) begin
        step_valid <= advance;
      end
      if (advance) begin
        error_sum      <= error_sum_next;
        previous_error <= err;
      end
    end
    if (s_tvalid && in_ready) begin
      in_pos   <= s_tdata;
      in_start <= s_tuser;
    end
    if (advance) begin
      step.err       <= err;
      step.deriv     <= deriv;
      step.isum      <= error_sum_next;
      step.on_target <= on_tgt;
    end
  end

endmodule

// ----- sv/pdd_mac.sv -----
module pdd_mac
  import pdd_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step_valid,
  output logic                         step_ready,
  input  pdd_step_t                    step,
  input  logic signed [GainWidth-1:0]  gain_p,
  input  logic signed [GainWidth-1:0]  gain_i,
  input  logic signed [GainWidth-1:0]  gain_d,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [DriveWidth-1:0]        m_tdata,
  output logic                         m_tuser
);

  localparam int PWidth   = ErrWidth + GainWidth;
  localparam int IWidth   = SumWidth + GainWidth;
  localparam int DWidth   = DerivWidth + GainWidth;
  localparam int AccWidth = IWidth + 2;
  localparam int QWidth   = AccWidth - 8;

  logic                     prod_valid;
  logic                     prod_ready;
  logic signed [PWidth-1:0] prod_p;
  logic signed [IWidth-1:0] prod_i;
  logic signed [DWidth-1:0] prod_d;
  logic                     prod_on;
  logic                     out_ready;

  logic signed [AccWidth-1:0] acc;
  logic signed [QWidth-1:0]   quo;
  logic signed [DriveWidth-1:0] drive;

  assign out_ready  = !m_tvalid || m_tready;
  assign prod_ready = !prod_valid || out_ready;
  assign step_ready = prod_ready;

  always_comb begin
    acc = AccWidth'(prod_p) + AccWidth'(prod_i) + AccWidth'(prod_d);
    // divide by 256 rounding toward zero
    quo = acc[AccWidth-1:8];
    if (acc[AccWidth-1] && (acc[7:0] != 8'd0)) begin
      quo = quo + QWidth'(1);
    end
    if (prod_on) begin
      drive = '0;
    end else if (quo > QWidth'(PowerLimit)) begin
      drive = DriveWidth'(PowerLimit);
    end else if (quo < -QWidth'(PowerLimit)) begin
      drive = -DriveWidth'(PowerLimit);
    end else begin
      drive = quo[DriveWidth-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid <= step_valid;
      end
      if (out_ready) begin
        m_tvalid <= prod_valid;
      end
    end
    if (step_valid && prod_ready) begin
      prod_p  <= step.err * gain_p;
      prod_i  <= step.isum * gain_i;
      prod_d  <= step.deriv * gain_d;
      prod_on <= step.on_target;
    end
    if (prod_valid && out_ready) begin
      m_tdata <= drive;
      m_tuser <= prod_on;
    end
  end

endmodule

// ----- sv/pid_distance_drive.sv -----
// PID distance controller with an integral zone. Each input item is one
// encoder position sample (ticks, signed) with a move-start flag; each item
// yields exactly one result: a drive level clamped to +-100 and an on-target
// flag (error within 2 ticks, drive 0). A new item is taken every clock while
// the output is not held off; the path to the result runs through the input
// register, error and integral update, three parallel gain multiplies, then
// sum, truncation and clamp into the output register. The target in inches
// is converted to ticks in the cycle after it is written, so write registers
// while the stream is quiet.
module pid_distance_drive
  import pdd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [GainWidth-1:0] cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [PosWidth-1:0]  s_tdata,   // [23:0] measured_position
  input  logic                 s_tuser,   // [0] move_start
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [DriveWidth-1:0] m_tdata,  // [7:0] drive_level
  output logic                 m_tuser    // [0] on_target
);

  localparam int ProdWidth = InchWidth + 16;

  logic signed [InchWidth-1:0] target_inches;
  logic signed [GainWidth-1:0] gain_p;
  logic signed [GainWidth-1:0] gain_i;
  logic signed [GainWidth-1:0] gain_d;
  logic signed [TickWidth-1:0] target_ticks;

  logic [InchWidth-1:0]   inch_mag;
  logic [ProdWidth-1:0]   tick_prod;
  logic [TickWidth-1:0]   tick_mag;
  logic signed [TickWidth-1:0] target_ticks_next;

  logic      step_valid;
  logic      step_ready;
  pdd_step_t step;

  always_comb begin
    inch_mag = target_inches[InchWidth-1] ? InchWidth'(-target_inches)
                                          : InchWidth'(target_inches);
    tick_prod = ProdWidth'(inch_mag) * ProdWidth'(TicksPerInchQ8);
    tick_mag  = tick_prod[ProdWidth-1:8];
    target_ticks_next = target_inches[InchWidth-1] ? -$signed(tick_mag)
                                                   : $signed(tick_mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_inches <= '0;
      gain_p        <= '0;
      gain_i        <= '0;
      gain_d        <= '0;
      target_ticks  <= '0;
    end else begin
      target_ticks <= target_ticks_next;
      if (cfg_we) begin
        case (pdd_reg_t'(cfg_index))
          REG_TARGET_INCHES: target_inches <= cfg_data[InchWidth-1:0];
          REG_GAIN_P:        gain_p <= cfg_data;
          REG_GAIN_I:        gain_i <= cfg_data;
          REG_GAIN_D:        gain_d <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  pdd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .target_ticks (target_ticks),
    .step_valid   (step_valid),
    .step_ready   (step_ready),
    .step         (step)
  );

  pdd_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .step_valid (step_valid),
    .step_ready (step_ready),
    .step       (step),
    .gain_p     (gain_p),
    .gain_i     (gain_i),
    .gain_d     (gain_d),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

// ----- tb/sv/pid_distance_drive_tb.sv -----
module pid_distance_drive_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pdd_pkg::*;

  localparam int DrainPause    = 8;
  localparam int TailCycles    = 20;
  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 3000;
  localparam int PhaseCount    = 9;
  localparam int PhaseItems    = 120;

  class drive_scoreboard;
    typedef struct {
      logic signed [DriveWidth-1:0] drive;
      logic                         on_target;
    } drive_result_t;

    logic signed [InchWidth-1:0] target_inches;
    logic signed [GainWidth-1:0] kp, ki, kd;
    longint error_sum;
    longint last_error;
    drive_result_t drive_q[$];
    int errors;

    function new();
      target_inches = '0;
      kp = '0;
      ki = '0;
      kd = '0;
      error_sum = 0;
      last_error = 0;
      errors = 0;
    endfunction

    function void write_reg(pdd_reg_t idx, logic [GainWidth-1:0] value);
      case (idx)
        REG_TARGET_INCHES: target_inches = value[InchWidth-1:0];
        REG_GAIN_P:        kp = value;
        REG_GAIN_I:        ki = value;
        REG_GAIN_D:        kd = value;
        default: ;
      endcase
    endfunction

    // inches to ticks, Q.8 factor, truncated toward zero
    function longint target_ticks();
      longint inch, mag_ticks;
      inch = longint'(target_inches);
      mag_ticks = ((inch < 0 ? -inch : inch) * TicksPerInchQ8) / 256;
      return inch < 0 ? -mag_ticks : mag_ticks;
    endfunction

    function void note_input(logic [PosWidth-1:0] pos_bits, logic start);
      longint pos, err, mag_err, deriv, acc, power;
      drive_result_t r;
      pos = longint'($signed(pos_bits));
      err = target_ticks() - pos;
      mag_err = err < 0 ? -err : err;
      if (start) begin
        error_sum = 0;
        last_error = err;
      end
      if (mag_err <= StopBand) begin
        last_error = err;
        r.drive = '0;
        r.on_target = 1'b1;
      end else begin
        deriv = err - last_error;
        last_error = err;
        if (mag_err < IntegralZone) begin
          acc = error_sum + err;
          if (acc > 64'sd2147483647) acc = 64'sd2147483647;
          if (acc < -64'sd2147483648) acc = -64'sd2147483648;
          error_sum = acc;
        end
        power = (err * longint'(kp) + error_sum * longint'(ki) + deriv * longint'(kd)) / 256;
        if (power > PowerLimit) power = PowerLimit;
        if (power < -PowerLimit) power = -PowerLimit;
        r.drive = power[DriveWidth-1:0];
        r.on_target = 1'b0;
      end
      drive_q.push_back(r);
    endfunction

    function void check_result(logic [DriveWidth-1:0] drive, logic on_tgt);
      drive_result_t want;
      if (drive_q.size() == 0) begin
        errors++;
        $error("unexpected item: drive_level %0d on_target %0b", $signed(drive), on_tgt);
        return;
      end
      want = drive_q.pop_front();
      if (drive !== want.drive) begin
        errors++;
        $error("drive_level: expected %0d, got %0d", want.drive, $signed(drive));
      end
      if (on_tgt !== want.on_target) begin
        errors++;
        $error("on_target: expected %0b, got %0b", want.on_target, on_tgt);
      end
    endfunction

    function int pending();
      return drive_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [GainWidth-1:0]  cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [PosWidth-1:0]   s_tdata;   // [23:0] measured_position
  logic                  s_tuser;   // [0] move_start
  logic                  m_tvalid;
  logic                  m_tready;
  logic [DriveWidth-1:0] m_tdata;   // [7:0] drive_level
  logic                  m_tuser;   // [0] on_target

  drive_scoreboard sb = new();
  bit send_idle;
  bit sink_idle;
  bit hold_req;
  int idle_cycles = 0;

  pid_distance_drive uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done = 1'b0;
    m_tready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_done = 1'b1;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (sink_idle && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(1, 17) - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // called and returns at a falling edge; valid stays high for back-to-back items
  task automatic send_item(input logic [PosWidth-1:0] pos, input logic start);
    int gap;
    if (send_idle && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 17);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pos;
    s_tuser  <= start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(pos, start);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input pdd_reg_t idx, input logic [GainWidth-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic configure(input logic [InchWidth-1:0] inches,
                           input logic [GainWidth-1:0] p, i, d);
    wait_drained();
    repeat (DrainPause) @(negedge clk);
    write_reg(REG_TARGET_INCHES, {{(GainWidth-InchWidth){inches[InchWidth-1]}}, inches});
    write_reg(REG_GAIN_P, p);
    write_reg(REG_GAIN_I, i);
    write_reg(REG_GAIN_D, d);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [GainWidth-1:0] rand_gain();
    if ($urandom_range(0, 1)) return GainWidth'(int'($urandom_range(0, 2047)) - 1024);
    return GainWidth'($urandom);
  endfunction

  task automatic run_directed();
    longint t;
    t = sb.target_ticks();
    send_item('0, 1'b1);
    send_item(24'h800000, 1'b0);
    send_item(24'h7fffff, 1'b0);
    send_item(PosWidth'(t), 1'b1);       // on target right at move start
    send_item(PosWidth'(t - 2), 1'b0);
    send_item(PosWidth'(t + 2), 1'b0);
    send_item(PosWidth'(t - 3), 1'b0);
    send_item(PosWidth'(t + 3), 1'b0);
    send_item(PosWidth'(t - 9), 1'b0);   // integral zone edges
    send_item(PosWidth'(t + 9), 1'b0);
    send_item(PosWidth'(t - 10), 1'b0);
    send_item(PosWidth'(t + 10), 1'b0);
    send_item(PosWidth'(t - 11), 1'b0);
    send_item(PosWidth'(t - 5), 1'b1);
    send_item(PosWidth'(t - 8), 1'b0);
    send_item(PosWidth'(t + 1), 1'b0);
    s_tvalid <= 1'b0;
  endtask

  // moves that converge on the target, with random noise items mixed in
  task automatic run_phase(input int n_items);
    int sent, len, k, step, jitter;
    longint err, ticks;
    sent = 0;
    ticks = sb.target_ticks();
    while (sent < n_items) begin
      len = $urandom_range(5, 40);
      if ($urandom_range(0, 1)) err = ticks;
      else err = longint'($urandom_range(0, 60000)) - 30000;
      for (k = 0; k < len && sent < n_items; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          send_item(PosWidth'($urandom), 1'($urandom));
        end else begin
          send_item(PosWidth'(ticks - err), k == 0);
          step = int'($urandom_range(2, 5));
          jitter = int'($urandom_range(0, 6)) - 3;
          err = err - err / step + jitter;
        end
        sent++;
      end
    end
    s_tvalid <= 1'b0;
  endtask

  initial begin
    int ph;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_TARGET_INCHES;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    send_idle = 1'b1;
    sink_idle = 1'b1;
    hold_req = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    configure(13'd100, 16'h0100, 16'h0040, 16'h0080);
    run_directed();

    for (ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0:       configure(13'h0fff, 16'h7fff, 16'h7fff, 16'h7fff);
        1:       configure(13'h1000, 16'h8000, 16'h8000, 16'h8000);
        2:       configure('0, '0, '0, '0);
        default: configure(InchWidth'($urandom), rand_gain(), rand_gain(), rand_gain());
      endcase
      if (ph < 3) begin
        send_idle = 1'b1;
        sink_idle = 1'b1;
      end else if (ph == 3) begin
        // back-to-back items against a long output hold-off
        send_idle = 1'b0;
        sink_idle = 1'b1;
        hold_req = 1'b1;
      end else if (ph == PhaseCount - 1) begin
        send_idle = 1'b0;
        sink_idle = 1'b0;
      end else begin
        send_idle = 1'($urandom);
        sink_idle = 1'($urandom);
      end
      run_phase(PhaseItems);
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
